### rtl/heightmap_vertex_normal_top_defines.svh
// ----------------------------------------------------------------------------
// Heightmap vertex normal: assertion macros
// Concurrent checks on clk_i with reset rst_ni, removable with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_TOP_DEFINES_SVH
`define HEIGHTMAP_VERTEX_NORMAL_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define HVN_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hvn assertion failed");
// Next-cycle implication.
`define HVN_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hvn assertion failed");
`else
`define HVN_ASSERT_IMP(name, ante, cons)
`define HVN_ASSERT_NXT(name, ante, cons)
`endif

`endif

### rtl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Types and constants shared by the heightmap vertex normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package hvn_pkg;

  localparam int GRID_W = 9;
  localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;
  localparam int HB_W   = 8;
  localparam int NORM_W = 16;

  localparam int DIFF_W = 9;      // difference of two height bytes
  localparam int LEN_W  = 18;     // squared length of a raw triangle normal
  localparam int ACC_W  = 24;     // sum of up to six Q.20 components
  localparam int MAG_W  = 24;
  localparam int SQ_W   = 48;     // sum of squares of the accumulator
  localparam int RES_W  = 21;     // rounded ratio, up to 2^20

  // Shared divide / square-root unit.
  localparam int DIV_STEPS = 45;
  localparam int NUM_W     = 46;
  localparam int WIDE_W    = SQ_W + DIV_STEPS;
  localparam int ROOT_W    = 23;
  localparam int SREM_W    = 26;
  localparam int CNT_W     = 6;
  localparam int TRI_SHIFT = 42;  // 2*20+2
  localparam int OUT_SHIFT = 30;  // 2*14+2

  localparam int NBR   = 9;
  localparam int SLOTS = 6;
  localparam logic [MAG_W-1:0] Y_MAG = 24'd16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic            kind;
    logic [7:0]      pos_x;
    logic [7:0]      pos_z;
    logic [HB_W-1:0] height_byte;
  } hvn_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
  } hvn_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_READ, ST_TRI_SEL, ST_TRI_LD, ST_R_GO, ST_R_WAIT,
    ST_SQ, ST_F_GO, ST_F_WAIT, ST_DONE
  } hvn_state_e;

  typedef enum logic [2:0] {
    RP_IDLE, RP_LOAD, RP_DIV, RP_ROOT, RP_DONE
  } hvn_rphase_e;

  typedef struct packed {
    logic       capture;
    logic       mem_wr;
    logic       rd_en;
    logic [3:0] rd_idx;
    logic       ld_h;
    logic [3:0] ld_idx;
    logic       acc_clr;
    logic       tri_ld;
    logic [2:0] slot;
    logic       r_start;
    logic       r_final;
    logic [1:0] comp;
    logic       acc_add;
    logic       sq_step;
    logic       res_ld;
    logic       out_push;
  } hvn_cmd_t;

  typedef struct packed {
    logic             in_kind;
    logic [SLOTS-1:0] slot_en;
    logic             r_done;
    logic             out_full;
  } hvn_stat_t;

  // Offsets of neighbor read idx within the 3x3 window: dx = idx / 3.
  function automatic logic [1:0] nbr_dx(input logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // dz = idx % 3.
  function automatic logic [1:0] nbr_dz(input logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/heightmap_vertex_normal_top.sv
// Operation: a write stores its height byte; a query reads the 3x3 neighbor window, then
// runs the shared divide and square-root unit 3 times per adjacent triangle (fewer at the
// border) and 3 times for the final normalization.
// Throughput: one item at a time; the next item is taken while a result waits at the output.
// Reset: control state clears and grid_size returns to 256; the height store is not cleared.
`include "heightmap_vertex_normal_top_defines.svh"
`default_nettype none

// ----------------------------------------------------------------------------
// heightmap_vertex_normal_top
// Height grid with per-vertex normal queries averaged over adjacent triangles.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_top #(
  parameter int MAX_DIM = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hvn_pkg::hvn_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hvn_pkg::hvn_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic [hvn_pkg::GRID_W-1:0] cfg_data_i
);
  import hvn_pkg::*;

  hvn_cmd_t  cmd_w;
  hvn_stat_t stat_w;

  hvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat_w),
    .cmd_o       (cmd_w)
  );

  hvn_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_w),
    .stat_o      (stat_w),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A finished ratio is always consumed by the sequencer in the same cycle.
  `HVN_ASSERT_IMP(a_ratio_used, stat_w.r_done, cmd_w.acc_add || cmd_w.res_ld)
  // A result is only loaded when the output register is free or being drained.
  `HVN_ASSERT_IMP(a_push_room, cmd_w.out_push, !out_valid_o || out_ready_i)
  // After a transfer in, the block is busy in the next cycle.
  `HVN_ASSERT_NXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

endmodule

`default_nettype wire

### rtl/hvn_ratio.sv
// ----------------------------------------------------------------------------
// hvn_ratio
// Iterative unit: round(mag * 2^F / sqrt(sq)), ties away from zero, computed
// as r = (isqrt(floor(mag^2 * 2^(2F+2) / sq)) + 1) / 2, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_ratio (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [hvn_pkg::MAG_W-1:0] mag_i,
  input  logic [hvn_pkg::SQ_W-1:0]  sq_i,
  input  logic                     out_sel_i,
  output logic                     done_o,
  output logic [hvn_pkg::RES_W-1:0] res_o
);
  import hvn_pkg::*;

  hvn_rphase_e phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [2*MAG_W-1:0] mag2_q;
  logic [SQ_W-1:0]   sq_q;
  logic              sel_q, zero_q;
  logic [SQ_W-1:0]   rem_q;
  logic [NUM_W-1:0]  num_q;
  logic [SREM_W-1:0] srem_q;
  logic [ROOT_W-1:0] root_q;

  logic [WIDE_W-1:0] wide;
  logic [SQ_W:0]     rem2;
  logic              div_ge;
  logic [SREM_W-1:0] srem2, trial;
  logic              rt_ge;
  logic [ROOT_W:0]   rnd;

  always_comb begin
    wide   = WIDE_W'(mag2_q) << (sel_q ? OUT_SHIFT : TRI_SHIFT);
    rem2   = {rem_q, num_q[DIV_STEPS-1]};
    div_ge = rem2 >= {1'b0, sq_q};
    srem2  = {srem_q[SREM_W-3:0], num_q[NUM_W-1 -: 2]};
    trial  = SREM_W'({root_q, 2'b01});
    rt_ge  = srem2 >= trial;
    rnd    = {1'b0, root_q} + (ROOT_W+1)'(1);
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      RP_IDLE: if (start_i) begin
        phase_d = RP_LOAD;
      end
      RP_LOAD: phase_d = RP_DIV;
      RP_DIV:  if (cnt_q == CNT_W'(DIV_STEPS-1)) begin
        phase_d = RP_ROOT;
      end
      RP_ROOT: if (cnt_q == CNT_W'(ROOT_W-1)) begin
        phase_d = RP_DONE;
      end
      RP_DONE: phase_d = RP_IDLE;
      default: phase_d = RP_IDLE;
    endcase
  end

  always_comb begin
    done_o = (phase_q == RP_DONE);
    res_o  = zero_q ? '0 : rnd[RES_W:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= RP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      RP_IDLE: begin
        mag2_q <= mag_i * mag_i;
        sq_q   <= sq_i;
        sel_q  <= out_sel_i;
        zero_q <= (sq_i == '0);
      end
      RP_LOAD: begin
        rem_q <= wide[WIDE_W-1:DIV_STEPS];
        num_q <= {1'b0, wide[DIV_STEPS-1:0]};
        cnt_q <= '0;
      end
      RP_DIV: begin
        rem_q <= div_ge ? SQ_W'(rem2 - {1'b0, sq_q}) : rem2[SQ_W-1:0];
        num_q <= {1'b0, num_q[DIV_STEPS-2:0], div_ge};
        if (cnt_q == CNT_W'(DIV_STEPS-1)) begin
          cnt_q  <= '0;
          srem_q <= '0;
          root_q <= '0;
        end else begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      RP_ROOT: begin
        srem_q <= rt_ge ? srem2 - trial : srem2;
        root_q <= {root_q[ROOT_W-2:0], rt_ge};
        num_q  <= {num_q[NUM_W-3:0], 2'b00};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/hvn_datapath.sv
// ----------------------------------------------------------------------------
// hvn_datapath
// Height store, neighbor window, triangle setup, accumulators and the
// output register; drives the shared ratio unit.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_datapath #(
  parameter int MAX_DIM = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hvn_pkg::hvn_cmd_t           cmd_i,
  output hvn_pkg::hvn_stat_t          stat_o,
  input  hvn_pkg::hvn_in_t            in_data_i,
  input  logic                        cfg_we_i,
  input  logic [hvn_pkg::GRID_W-1:0]  cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output hvn_pkg::hvn_out_t           out_data_o
);
  import hvn_pkg::*;

  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int GW    = (CW > GRID_W) ? CW : GRID_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic [GRID_W-1:0] grid_q;
  logic [CW-1:0]     x_q, z_q, dm1_q;
  logic [HB_W-1:0]   hb_q;
  logic [HB_W-1:0]   mem_q [DEPTH];
  logic [HB_W-1:0]   rd_data_q;
  logic [HB_W-1:0]   h_q [NBR];
  logic signed [DIFF_W-1:0] a_q, b_q;
  logic [LEN_W-1:0]  len_q;
  logic signed [ACC_W-1:0]  acc_q [3];
  logic [SQ_W-1:0]   sq_q;
  logic signed [NORM_W-1:0] res_q [3];
  logic              out_valid_q;
  hvn_out_t          out_q;

  logic [GW-1:0] g, d, px, pz;
  logic [CW-1:0] nx, nz;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [HB_W-1:0] h00, h01, h10, h11;
  logic          use_t1;
  logic signed [DIFF_W-1:0] a_n, b_n;
  logic signed [LEN_W-1:0]  aa, bb;
  logic [MAG_W-1:0] mag_tri, mag_fin, r_mag;
  logic [SQ_W-1:0]  mag_sq;
  logic             neg_tri, neg_fin, neg;
  logic signed [ACC_W-1:0]  acc_sel;
  logic [RES_W-1:0]  r_res;
  logic              r_done;
  logic signed [ACC_W-1:0]  radd;
  logic signed [NORM_W-1:0] rnorm;

  // Effective grid size and coordinates; a coordinate outside the grid acts as 0.
  always_comb begin
    g  = GW'(grid_q);
    d  = (g < GW'(2)) ? GW'(2) : ((g > GW'(MAX_DIM)) ? GW'(MAX_DIM) : g);
    px = GW'(in_data_i.pos_x);
    pz = GW'(in_data_i.pos_z);
    if (px >= d) px = '0;
    if (pz >= d) pz = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      grid_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q   <= CW'(px);
      z_q   <= CW'(pz);
      dm1_q <= CW'(d - GW'(1));
      hb_q  <= in_data_i.height_byte;
    end
  end

  always_comb begin
    nx      = x_q + CW'(nbr_dx(cmd_i.rd_idx)) - CW'(1);
    nz      = z_q + CW'(nbr_dz(cmd_i.rd_idx)) - CW'(1);
    wr_addr = AW'(x_q * MAX_DIM + z_q);
    // Window entries off the grid are never used; read a safe address.
    if ((int'(nx) < MAX_DIM) && (int'(nz) < MAX_DIM)) begin
      rd_addr = AW'(nx * MAX_DIM + nz);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[wr_addr] <= hb_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_h) begin
      h_q[cmd_i.ld_idx] <= rd_data_q;
    end
  end

  // The window is h_q[dx*3+dz] with (dx,dz) relative to (X-1,Z-1).
  always_comb begin
    case (cmd_i.slot)
      3'd0:    begin h00 = h_q[0]; h01 = h_q[1]; h10 = h_q[3]; h11 = h_q[4]; use_t1 = 1'b0; end
      3'd1:    begin h00 = h_q[0]; h01 = h_q[1]; h10 = h_q[3]; h11 = h_q[4]; use_t1 = 1'b1; end
      3'd2:    begin h00 = h_q[3]; h01 = h_q[4]; h10 = h_q[6]; h11 = h_q[7]; use_t1 = 1'b0; end
      3'd3:    begin h00 = h_q[4]; h01 = h_q[5]; h10 = h_q[7]; h11 = h_q[8]; use_t1 = 1'b0; end
      3'd4:    begin h00 = h_q[4]; h01 = h_q[5]; h10 = h_q[7]; h11 = h_q[8]; use_t1 = 1'b1; end
      default: begin h00 = h_q[1]; h01 = h_q[2]; h10 = h_q[4]; h11 = h_q[5]; use_t1 = 1'b1; end
    endcase
    if (use_t1) begin
      a_n = $signed({1'b0, h11}) - $signed({1'b0, h01});
      b_n = $signed({1'b0, h01}) - $signed({1'b0, h00});
    end else begin
      a_n = $signed({1'b0, h10}) - $signed({1'b0, h00});
      b_n = $signed({1'b0, h11}) - $signed({1'b0, h10});
    end
    aa = LEN_W'(a_n) * LEN_W'(a_n);
    bb = LEN_W'(b_n) * LEN_W'(b_n);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tri_ld) begin
      a_q   <= a_n;
      b_q   <= b_n;
      len_q <= LEN_W'(aa) + LEN_W'(bb) + LEN_W'(256);
    end
  end

  // Operand and sign of the component in work.
  always_comb begin
    case (cmd_i.comp)
      COMP_X:  begin
        mag_tri = MAG_W'(a_q[DIFF_W-1] ? -a_q : a_q);
        neg_tri = a_q[DIFF_W-1];
      end
      COMP_Y:  begin
        mag_tri = Y_MAG;
        neg_tri = 1'b1;
      end
      default: begin
        mag_tri = MAG_W'(b_q[DIFF_W-1] ? -b_q : b_q);
        neg_tri = b_q[DIFF_W-1];
      end
    endcase
    acc_sel = acc_q[cmd_i.comp];
    neg_fin = acc_sel[ACC_W-1];
    mag_fin = MAG_W'(neg_fin ? -acc_sel : acc_sel);
    mag_sq  = mag_fin * mag_fin;
    r_mag   = cmd_i.r_final ? mag_fin : mag_tri;
    neg     = cmd_i.r_final ? neg_fin : neg_tri;
    radd    = $signed(ACC_W'(r_res));
    rnorm   = $signed(NORM_W'(r_res));
  end

  hvn_ratio u_ratio (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.r_start),
    .mag_i     (r_mag),
    .sq_i      (cmd_i.r_final ? sq_q : SQ_W'(len_q)),
    .out_sel_i (cmd_i.r_final),
    .done_o    (r_done),
    .res_o     (r_res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      sq_q     <= '0;
    end else begin
      if (cmd_i.acc_add) begin
        acc_q[cmd_i.comp] <= neg ? acc_sel - radd : acc_sel + radd;
      end
      if (cmd_i.sq_step) begin
        sq_q <= sq_q + mag_sq;
      end
    end
    if (cmd_i.res_ld) begin
      res_q[cmd_i.comp] <= neg ? -rnorm : rnorm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_push) begin
      out_q.normal_x <= res_q[0];
      out_q.normal_y <= res_q[1];
      out_q.normal_z <= res_q[2];
    end
  end

  always_comb begin
    stat_o.in_kind    = in_data_i.kind;
    stat_o.slot_en[0] = (x_q != '0) && (z_q != '0);
    stat_o.slot_en[1] = (x_q != '0) && (z_q != '0);
    stat_o.slot_en[2] = (z_q != '0) && (x_q != dm1_q);
    stat_o.slot_en[3] = (x_q != dm1_q) && (z_q != dm1_q);
    stat_o.slot_en[4] = (x_q != dm1_q) && (z_q != dm1_q);
    stat_o.slot_en[5] = (x_q != '0) && (z_q != dm1_q);
    stat_o.r_done     = r_done;
    stat_o.out_full   = out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/hvn_ctrl.sv
// ----------------------------------------------------------------------------
// hvn_ctrl
// Sequencer: window reads, triangle terms, final normalization, output.
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  input  hvn_pkg::hvn_stat_t stat_i,
  output hvn_pkg::hvn_cmd_t  cmd_o
);
  import hvn_pkg::*;

  hvn_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        state_d = (stat_i.in_kind == KIND_QUERY) ? ST_READ : ST_WRITE;
        cnt_d   = '0;
      end
      ST_WRITE: state_d = ST_IDLE;
      ST_READ: begin
        if (cnt_q == 4'(NBR)) begin
          state_d = ST_TRI_SEL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_TRI_SEL: begin
        if (cnt_q == 4'(SLOTS)) begin
          state_d = ST_SQ;
          comp_d  = COMP_X;
        end else if (stat_i.slot_en[cnt_q[2:0]]) begin
          state_d = ST_TRI_LD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_TRI_LD: begin
        state_d = ST_R_GO;
        comp_d  = COMP_X;
      end
      ST_R_GO: state_d = ST_R_WAIT;
      ST_R_WAIT: if (stat_i.r_done) begin
        if (comp_q == COMP_Z) begin
          state_d = ST_TRI_SEL;
          cnt_d   = cnt_q + 4'd1;
        end else begin
          state_d = ST_R_GO;
          comp_d  = comp_q + 2'd1;
        end
      end
      ST_SQ: begin
        if (comp_q == COMP_Z) begin
          state_d = ST_F_GO;
          comp_d  = COMP_X;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      ST_F_GO: state_d = ST_F_WAIT;
      ST_F_WAIT: if (stat_i.r_done) begin
        if (comp_q == COMP_Z) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_F_GO;
          comp_d  = comp_q + 2'd1;
        end
      end
      ST_DONE: if (!stat_i.out_full || out_ready_i) begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_idx = cnt_q;
    cmd_o.ld_idx = cnt_q - 4'd1;
    cmd_o.slot   = cnt_q[2:0];
    cmd_o.comp   = comp_q;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_WRITE: cmd_o.mem_wr = 1'b1;
      ST_READ: begin
        cmd_o.rd_en   = (cnt_q != 4'(NBR));
        cmd_o.ld_h    = (cnt_q != 4'd0);
        cmd_o.acc_clr = (cnt_q == 4'(NBR));
      end
      ST_TRI_SEL: ;
      ST_TRI_LD: cmd_o.tri_ld = 1'b1;
      ST_R_GO:   cmd_o.r_start = 1'b1;
      ST_R_WAIT: cmd_o.acc_add = stat_i.r_done;
      ST_SQ:     cmd_o.sq_step = 1'b1;
      ST_F_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.r_final = 1'b1;
      end
      ST_F_WAIT: begin
        cmd_o.r_final = 1'b1;
        cmd_o.res_ld  = stat_i.r_done;
      end
      ST_DONE: cmd_o.out_push = !stat_i.out_full || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= COMP_X;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
    end
  end

endmodule

`default_nettype wire
